[design/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 16;
    localparam int POS_W     = 5;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SRCH = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_EMPTY   = 2'd1,
        STS_FULL    = 2'd2,
        STS_NOMATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_ENQ_PUT,
        ST_DEQ_HEAD,
        ST_DEQ_SHIFT,
        ST_SRCH,
        ST_RESP
    } t_state;

    // one stored pair, value in the low half
    typedef struct packed {
        logic signed [VAL_W-1:0] pri;
        logic signed [VAL_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic eq;   // stored value equals key value
        logic gt;   // stored priority above key priority
    } t_cmp;

    typedef struct packed {
        t_status          status;
        t_entry           entry;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] occ;
        logic             last;
    } t_res;

endpackage

[design/spq_store.sv]
// Entry memory: one write port, one read port with registered data.
module spq_store #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  spq_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output spq_pkg::t_entry o_rd_data
);

    spq_pkg::t_entry r_mem [DEPTH];
    spq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/spq_cmp.sv]
// Shared compare unit: value match and signed priority order.
module spq_cmp (
    input  spq_pkg::t_entry i_entry,
    input  spq_pkg::t_entry i_key,
    output spq_pkg::t_cmp   o_cmp
);

    assign o_cmp.eq = (i_entry.val == i_key.val);
    assign o_cmp.gt = ($signed(i_entry.pri) > $signed(i_key.pri));

endmodule

[design/spq_seq.sv]
// Sequencer: insert, remove, search walk memory one slot a cycle unless stalled.
module spq_seq #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  spq_pkg::t_op    i_opcode,
    input  spq_pkg::t_entry i_key,
    input  logic            i_res_ready,
    output logic            o_res_valid,
    output spq_pkg::t_res   o_res,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  spq_pkg::t_entry i_rd_data,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output spq_pkg::t_entry o_wr_data
);

    spq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    spq_pkg::t_entry  r_key, n_key;
    logic             r_pend_v, n_pend_v;
    spq_pkg::t_status r_pend_st, n_pend_st;
    spq_pkg::t_entry  r_pend, n_pend;
    logic [spq_pkg::POS_W-1:0] r_pend_pos, n_pend_pos;

    spq_pkg::t_cmp cmp;
    logic          accept;
    logic          full;
    logic          empty;
    logic          at_last;
    logic          at_head;
    logic          stall;
    logic          res_last;

    spq_cmp u_cmp (
        .i_entry (i_rd_data),
        .i_key   (r_key),
        .o_cmp   (cmp)
    );

    assign accept  = i_in_valid && o_in_ready;
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign at_last = (CW'(r_idx) == r_count - CW'(1));
    assign at_head = (r_idx == '0);
    // a second match may not overwrite the held one until it is sent
    assign stall   = cmp.eq && r_pend_v && !i_res_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        spq_pkg::OP_ENQ: begin
                            if (full) begin
                                n_state = spq_pkg::ST_RESP;
                            end else if (empty) begin
                                n_state = spq_pkg::ST_ENQ_PUT;
                            end else begin
                                n_state = spq_pkg::ST_ENQ;
                            end
                        end
                        spq_pkg::OP_DEQ: begin
                            n_state = empty ? spq_pkg::ST_RESP : spq_pkg::ST_DEQ_HEAD;
                        end
                        spq_pkg::OP_SRCH: begin
                            n_state = empty ? spq_pkg::ST_RESP : spq_pkg::ST_SRCH;
                        end
                        default: begin
                            n_state = spq_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            spq_pkg::ST_ENQ: begin
                if (!cmp.gt) begin
                    n_state = spq_pkg::ST_RESP;
                end else if (at_head) begin
                    n_state = spq_pkg::ST_ENQ_PUT;
                end
            end
            spq_pkg::ST_ENQ_PUT: begin
                n_state = spq_pkg::ST_RESP;
            end
            spq_pkg::ST_DEQ_HEAD: begin
                n_state = (r_count == CW'(1)) ? spq_pkg::ST_RESP : spq_pkg::ST_DEQ_SHIFT;
            end
            spq_pkg::ST_DEQ_SHIFT: begin
                if (at_last) begin
                    n_state = spq_pkg::ST_RESP;
                end
            end
            spq_pkg::ST_SRCH: begin
                if (!stall && at_last) begin
                    n_state = spq_pkg::ST_RESP;
                end
            end
            spq_pkg::ST_RESP: begin
                if (i_res_ready) begin
                    n_state = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // memory and handshake controls
    always_comb begin
        o_in_ready  = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = r_key;
        o_res_valid = 1'b0;
        res_last    = 1'b1;
        case (r_state)
            spq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept && !empty) begin
                    case (i_opcode)
                        spq_pkg::OP_ENQ: begin
                            // walk from the tail toward the head
                            o_rd_en   = !full;
                            o_rd_addr = AW'(r_count - CW'(1));
                        end
                        spq_pkg::OP_DEQ, spq_pkg::OP_SRCH: begin
                            o_rd_en = 1'b1;
                        end
                        default: begin
                            o_rd_en = 1'b0;
                        end
                    endcase
                end
            end
            spq_pkg::ST_ENQ: begin
                // move the entry up one slot, or drop the new pair behind it
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx + AW'(1);
                o_wr_data = cmp.gt ? i_rd_data : r_key;
                if (cmp.gt && !at_head) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx - AW'(1);
                end
            end
            spq_pkg::ST_ENQ_PUT: begin
                o_wr_en = 1'b1;
            end
            spq_pkg::ST_DEQ_HEAD: begin
                if (r_count != CW'(1)) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(1);
                end
            end
            spq_pkg::ST_DEQ_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx - AW'(1);
                o_wr_data = i_rd_data;
                if (!at_last) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                end
            end
            spq_pkg::ST_SRCH: begin
                res_last    = 1'b0;
                o_res_valid = cmp.eq && r_pend_v && i_res_ready;
                if (!stall && !at_last) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                end
            end
            spq_pkg::ST_RESP: begin
                o_res_valid = i_res_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // index, count and held result
    always_comb begin
        n_idx      = r_idx;
        n_count    = r_count;
        n_key      = r_key;
        n_pend_v   = r_pend_v;
        n_pend_st  = r_pend_st;
        n_pend     = r_pend;
        n_pend_pos = r_pend_pos;
        case (r_state)
            spq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_key      = i_key;
                    n_pend_v   = 1'b0;
                    n_pend     = '0;
                    n_pend_pos = '0;
                    n_idx      = '0;
                    case (i_opcode)
                        spq_pkg::OP_ENQ: begin
                            n_pend_st = full ? spq_pkg::STS_FULL : spq_pkg::STS_OK;
                            n_idx     = AW'(r_count - CW'(1));
                        end
                        spq_pkg::OP_DEQ: begin
                            n_pend_st = empty ? spq_pkg::STS_EMPTY : spq_pkg::STS_OK;
                        end
                        spq_pkg::OP_SRCH: begin
                            n_pend_st = spq_pkg::STS_NOMATCH;
                        end
                        default: begin
                            n_pend_st = spq_pkg::STS_OK;
                        end
                    endcase
                end
            end
            spq_pkg::ST_ENQ: begin
                if (!cmp.gt) begin
                    n_count = r_count + CW'(1);
                end else if (!at_head) begin
                    n_idx = r_idx - AW'(1);
                end
            end
            spq_pkg::ST_ENQ_PUT: begin
                n_count = r_count + CW'(1);
            end
            spq_pkg::ST_DEQ_HEAD: begin
                n_pend = i_rd_data;
                if (r_count == CW'(1)) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_idx = AW'(1);
                end
            end
            spq_pkg::ST_DEQ_SHIFT: begin
                if (at_last) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            spq_pkg::ST_SRCH: begin
                if (!stall) begin
                    if (cmp.eq) begin
                        n_pend_v   = 1'b1;
                        n_pend_st  = spq_pkg::STS_OK;
                        n_pend     = i_rd_data;
                        n_pend_pos = spq_pkg::POS_W'({1'b0, r_idx} + (AW+1)'(1));
                    end
                    if (!at_last) begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spq_pkg::ST_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_pend_st  <= n_pend_st;
        r_pend     <= n_pend;
        r_pend_pos <= n_pend_pos;
    end

    assign o_res.status = r_pend_st;
    assign o_res.entry  = r_pend;
    assign o_res.pos    = r_pend_pos;
    assign o_res.occ    = spq_pkg::POS_W'(r_count);
    assign o_res.last   = res_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
        (r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    a_res_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_res_ready)
        else $error("result sent while output register busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != spq_pkg::ST_IDLE))
        else $error("sequencer idle right after accepting a word");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq_pkg::ST_IDLE) |-> !o_wr_en)
        else $error("memory written while idle");
`endif

endmodule

[design/sorted_priority_queue.sv]
// Sorted priority queue: top level with stream ports and result register.
// Every operation ends with a word through the result register; full, empty and no-op
//   words go there without walking the entry memory.
// Throughput: one word at a time; the count scales the time as the sequencer walks the memory
//   one slot per cycle, unless a search match waits to be sent, through its single port pair.
// Reset: synchronous active low; the queue empties at once, entry memory is not cleared.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // item_value[15:0], item_priority[31:16]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_value[15:0], out_priority[31:16],
                                        // position[36:32], occupancy[41:37], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::t_entry key;
    spq_pkg::t_entry rd_data;
    spq_pkg::t_entry wr_data;
    spq_pkg::t_res   res;
    logic            res_valid;
    logic            res_ready;
    logic            rd_en;
    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    // result register; the sequencer only emits when it is free or draining
    logic            r_out_valid;
    spq_pkg::t_res   r_out;

    assign key.val = s_axis_tdata[15:0];
    assign key.pri = s_axis_tdata[31:16];

    assign res_ready = !r_out_valid || m_axis_tready;

    spq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    spq_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (spq_pkg::t_op'(s_axis_tuser)),
        .i_key       (key),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {6'd0, r_out.occ, r_out.pos, r_out.entry.pri, r_out.entry.val};

endmodule
